/* rtl/core/rsi_pkg.sv */
package rsi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SQ_ITER = (64 + FRAC_BITS + 1) / 2;
   localparam int SQ_W = SQ_ITER;
   localparam int SQ_CNT_W = $clog2(SQ_ITER);
   localparam int NRM_W = 18;
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int T_W = 34;

   localparam logic signed [63:0] SAT64 = 64'sh7FFF_FFFF_FFFF_FFFF;

   localparam logic [2:0] REG_CX    = 3'd0;
   localparam logic [2:0] REG_CY    = 3'd1;
   localparam logic [2:0] REG_CZ    = 3'd2;
   localparam logic [2:0] REG_RAD   = 3'd3;
   localparam logic [2:0] REG_COLOR = 3'd4;

   typedef struct packed {
      logic [31:0] cx;
      logic [31:0] cy;
      logic [31:0] cz;
      logic [30:0] radius;
      logic [23:0] color;
   } rsi_cfg_type;

   typedef struct packed {
      logic [31:0] ox;
      logic [31:0] oy;
      logic [31:0] oz;
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] dz;
      logic [31:0] tlo;
      logic [31:0] thi;
      logic [32:0] ocx;
      logic [32:0] ocy;
      logic [32:0] ocz;
      logic        skip;
   } rsi_ray_type;

   typedef struct packed {
      logic                   hit;
      logic [31:0]            t;
      logic [2:0][31:0]       p;
      logic [2:0][NRM_W-1:0]  nrm;
      logic [23:0]            color;
   } rsi_rsp_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
      logic signed [64:0] s;
      s = 65'(x) + 65'(y);
      if (s > 65'(SAT64)) begin
         return SAT64;
      end else if (s < -65'(SAT64)) begin
         return -SAT64;
      end else begin
         return s[63:0];
      end
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
      return sat_add(x, -y);
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] x);
      logic signed [63:0] nx;
      nx = -x;
      return x[63] ? nx : x;
   endfunction

   function automatic logic [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end else if (v < -64'sh8000_0000) begin
         return 32'h8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

endpackage

/* rtl/core/rsi_front.sv */
module rsi_front import rsi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] origin_x,
   input  logic [31:0] origin_y,
   input  logic [31:0] origin_z,
   input  logic [31:0] dir_x,
   input  logic [31:0] dir_y,
   input  logic [31:0] dir_z,
   input  logic [31:0] t_low,
   input  logic [31:0] t_high,
   input  rsi_cfg_type cfg,
   input  logic        q_full,
   output logic        q_push,
   output rsi_ray_type q_data
);

   logic        valid_ff, valid_in;
   rsi_ray_type data_ff, data_in;
   logic        accept;

   assign full   = valid_ff & q_full;
   assign q_push = valid_ff & ~q_full;
   assign accept = push & ~full;
   assign q_data = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in     = 1'b1;
         data_in.ox   = origin_x;
         data_in.oy   = origin_y;
         data_in.oz   = origin_z;
         data_in.dx   = dir_x;
         data_in.dy   = dir_y;
         data_in.dz   = dir_z;
         data_in.tlo  = t_low;
         data_in.thi  = t_high;
         data_in.ocx  = 33'($signed(origin_x)) - 33'($signed(cfg.cx));
         data_in.ocy  = 33'($signed(origin_y)) - 33'($signed(cfg.cy));
         data_in.ocz  = 33'($signed(origin_z)) - 33'($signed(cfg.cz));
         data_in.skip = $signed(t_low) > $signed(t_high);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

/* rtl/core/rsi_queue.sv */
module rsi_queue import rsi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  rsi_ray_type data_in,
   output logic        full,
   input  logic        pop,
   output logic        empty,
   output rsi_ray_type data_out
);

   rsi_ray_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]         cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign full     = cnt_ff == (QPTR_W+1)'(QDEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign data_out = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= data_in;
      end
   end

endmodule

/* rtl/core/rsi_mul.sv */
module rsi_mul import rsi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] x,
   input  logic signed [63:0] y,
   output logic               done,
   output logic signed [63:0] prod
);

   logic               busy_ff, busy_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [63:0]        xm_ff, xm_in, ym_ff, ym_in;
   logic               neg_ff, neg_in;
   logic [63:0]        pp_ff, pp_in;
   logic [1:0]         sh_ff, sh_in;
   logic [127:0]       acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [31:0]        xa, yb;
   logic [127:0]       shifted;
   logic [63:0]        m;

   assign done = done_ff;
   assign prod = prod_ff;

   always_comb begin
      xa      = cnt_ff[1] ? xm_ff[63:32] : xm_ff[31:0];
      yb      = cnt_ff[0] ? ym_ff[63:32] : ym_ff[31:0];
      shifted = acc_ff >> FRAC_BITS;
      m       = (|shifted[127:63]) ? SAT64 : {1'b0, shifted[62:0]};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      xm_in   = xm_ff;
      ym_in   = ym_ff;
      neg_in  = neg_ff;
      pp_in   = pp_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff < 3'd4) begin
            pp_in = xa * yb;
            sh_in = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
         end
         if (cnt_ff >= 3'd1 && cnt_ff <= 3'd4) begin
            acc_in = acc_ff + (128'(pp_ff) << {sh_ff, 5'b0});
         end
         if (cnt_ff == 3'd5) begin
            prod_in = neg_ff ? -$signed(m) : $signed(m);
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         xm_in   = mag64(x);
         ym_in   = mag64(y);
         neg_in  = x[63] ^ y[63];
         acc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      xm_ff   <= xm_in;
      ym_ff   <= ym_in;
      neg_ff  <= neg_in;
      pp_ff   <= pp_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

endmodule

/* rtl/core/rsi_sqrt.sv */
module rsi_sqrt import rsi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [63:0]     v,
   output logic            done,
   output logic [SQ_W-1:0] root
);

   localparam int RAD_W = 2 * SQ_ITER;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [SQ_ITER+2:0]  rem_ff, rem_in;
   logic [SQ_W-1:0]     root_ff, root_in;
   logic [SQ_ITER+2:0]  rem_sh, trial;

   assign done = done_ff;
   assign root = root_ff;

   always_comb begin
      rem_sh  = {rem_ff[SQ_ITER:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (busy_ff) begin
         rad_in = rad_ff << 2;
         cnt_in = cnt_ff + 1'b1;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[SQ_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[SQ_W-2:0], 1'b0};
         end
         if (cnt_ff == SQ_CNT_W'(SQ_ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = RAD_W'({v, {FRAC_BITS{1'b0}}});
         rem_in  = '0;
         root_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

/* rtl/core/rsi_div.sv */
module rsi_div import rsi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  num,
   input  logic [63:0]         den,
   output logic                done,
   output logic signed [T_W-1:0] quo
);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_CHK  = 2'd1;
   localparam logic [1:0] D_RUN  = 2'd2;
   localparam logic [1:0] D_FIN  = 2'd3;

   logic [1:0]            st_ff, st_in;
   logic                  done_ff, done_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [63:0]           n_ff, n_in, den_ff, den_in, rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           low_ff, low_in, q_ff, q_in;
   logic signed [T_W-1:0] quo_ff, quo_in;
   logic [63+FRAC_BITS:0] nsh;
   logic                  big, ge;
   logic [64:0]           rem_sh, rem_dif;

   assign done = done_ff;
   assign quo  = quo_ff;

   always_comb begin
      nsh     = {n_ff, {FRAC_BITS{1'b0}}};
      big     = 97'(nsh) >= 97'({den_ff, 32'b0});
      rem_sh  = {rem_ff, low_ff[31]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_dif = rem_sh - {1'b0, den_ff};
      st_in   = st_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      quo_in  = quo_ff;
      case (st_ff)
         D_IDLE: begin
            if (start) begin
               n_in   = mag64(num);
               den_in = den;
               neg_in = num[63];
               st_in  = D_CHK;
            end
         end
         D_CHK: begin
            if (big) begin
               quo_in  = neg_ff ? -(T_W'(1) << 32) : (T_W'(1) << 32);
               done_in = 1'b1;
               st_in   = D_IDLE;
            end else begin
               rem_in = 64'(nsh[63+FRAC_BITS:32]);
               low_in = nsh[31:0];
               q_in   = '0;
               cnt_in = '0;
               st_in  = D_RUN;
            end
         end
         D_RUN: begin
            rem_in = ge ? rem_dif[63:0] : rem_sh[63:0];
            q_in   = {q_ff[30:0], ge};
            low_in = low_ff << 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               st_in = D_FIN;
            end
         end
         D_FIN: begin
            quo_in  = neg_ff ? -$signed(T_W'(q_ff)) : $signed(T_W'(q_ff));
            done_in = 1'b1;
            st_in   = D_IDLE;
         end
         default: begin
            st_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= D_IDLE;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      n_ff   <= n_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      quo_ff <= quo_in;
   end

endmodule

/* rtl/core/rsi_back.sv */
module rsi_back import rsi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rsi_cfg_type cfg,
   input  logic        q_empty,
   input  rsi_ray_type q_data,
   output logic        q_pop,
   output logic        empty,
   input  logic        pop,
   output rsi_rsp_type rsp
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_A    = 4'd1;
   localparam logic [3:0] S_H    = 4'd2;
   localparam logic [3:0] S_C    = 4'd3;
   localparam logic [3:0] S_R    = 4'd4;
   localparam logic [3:0] S_HH   = 4'd5;
   localparam logic [3:0] S_AC   = 4'd6;
   localparam logic [3:0] S_SQ   = 4'd7;
   localparam logic [3:0] S_D1   = 4'd8;
   localparam logic [3:0] S_D2   = 4'd9;
   localparam logic [3:0] S_P    = 4'd10;
   localparam logic [3:0] S_N    = 4'd11;
   localparam logic [3:0] S_L    = 4'd12;
   localparam logic [3:0] S_Q    = 4'd13;
   localparam logic [3:0] S_OUT  = 4'd14;
   localparam logic [3:0] S_MISS = 4'd15;

   localparam logic signed [T_W-1:0] NRM_ONE = T_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic signed [63:0]    a;
      logic signed [63:0]    h;
      logic signed [63:0]    cc;
      logic signed [63:0]    tmp;
      logic signed [63:0]    nn;
      logic [SQ_W-1:0]       s;
      logic [SQ_W-1:0]       len;
      logic [T_W-1:0]        t;
      logic [2:0][31:0]      p;
      logic [2:0][NRM_W-1:0] nrm;
   } rsi_work_type;

   logic [3:0]          st_ff, st_in;
   logic [1:0]          idx_ff, idx_in;
   logic                busy_ff, busy_in;
   logic                rv_ff, rv_in;
   rsi_ray_type         item_ff, item_in;
   rsi_work_type        w_ff, w_in;
   rsi_rsp_type         rsp_ff, rsp_in;

   logic                mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
   logic signed [63:0]  mul_x, mul_y, mul_prod, div_num, s64, acc;
   logic [63:0]         sqrt_v, div_den;
   logic [SQ_W-1:0]     root;
   logic signed [T_W-1:0] quo;
   logic [31:0]         d_sel, o_sel, p_sel, c_sel;
   logic [32:0]         oc_sel;
   logic signed [32:0]  nv_sel;
   logic                in_win;

   assign empty = ~rv_ff;
   assign rsp   = rsp_ff;

   always_comb begin
      case (idx_ff)
         2'd0: begin
            d_sel = item_ff.dx; o_sel = item_ff.ox; oc_sel = item_ff.ocx;
            p_sel = w_ff.p[0];  c_sel = cfg.cx;
         end
         2'd1: begin
            d_sel = item_ff.dy; o_sel = item_ff.oy; oc_sel = item_ff.ocy;
            p_sel = w_ff.p[1];  c_sel = cfg.cy;
         end
         default: begin
            d_sel = item_ff.dz; o_sel = item_ff.oz; oc_sel = item_ff.ocz;
            p_sel = w_ff.p[2];  c_sel = cfg.cz;
         end
      endcase
      nv_sel = 33'($signed(p_sel)) - 33'($signed(c_sel));
      s64    = $signed(64'(w_ff.s));
      in_win = ($signed(quo) >= T_W'($signed(item_ff.tlo)))
               && ($signed(quo) <= T_W'($signed(item_ff.thi)));

      case (st_ff)
         S_A: begin
            mul_x = 64'($signed(d_sel)); mul_y = 64'($signed(d_sel));
         end
         S_H: begin
            mul_x = 64'($signed(oc_sel)); mul_y = 64'($signed(d_sel));
         end
         S_C: begin
            mul_x = 64'($signed(oc_sel)); mul_y = 64'($signed(oc_sel));
         end
         S_R: begin
            mul_x = $signed(64'(cfg.radius)); mul_y = $signed(64'(cfg.radius));
         end
         S_HH: begin
            mul_x = w_ff.h; mul_y = w_ff.h;
         end
         S_AC: begin
            mul_x = w_ff.a; mul_y = w_ff.cc;
         end
         S_P: begin
            mul_x = 64'($signed(d_sel)); mul_y = 64'($signed(w_ff.t));
         end
         default: begin
            mul_x = 64'($signed(nv_sel)); mul_y = 64'($signed(nv_sel));
         end
      endcase
      mul_start  = (st_ff inside {S_A, S_H, S_C, S_R, S_HH, S_AC, S_P, S_N}) && !busy_ff;
      sqrt_start = (st_ff inside {S_SQ, S_L}) && !busy_ff;
      div_start  = (st_ff inside {S_D1, S_D2, S_Q}) && !busy_ff;
      sqrt_v     = (st_ff == S_SQ) ? w_ff.tmp : w_ff.nn;
      case (st_ff)
         S_D1:    div_num = sat_sub(-w_ff.h, s64);
         S_D2:    div_num = sat_add(-w_ff.h, s64);
         default: div_num = 64'($signed(nv_sel));
      endcase
      div_den = (st_ff == S_Q) ? 64'(w_ff.len) : w_ff.a;
   end

   rsi_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start), .x (mul_x), .y (mul_y),
      .done  (mul_done), .prod (mul_prod)
   );

   rsi_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sqrt_start), .v (sqrt_v),
      .done  (sqrt_done), .root (root)
   );

   rsi_div u_div (
      .clock (clock), .reset (reset), .start (div_start), .num (div_num),
      .den   (div_den), .done (div_done), .quo (quo)
   );

   always_comb begin
      st_in   = st_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      rv_in   = rv_ff;
      item_in = item_ff;
      w_in    = w_ff;
      rsp_in  = rsp_ff;
      q_pop   = 1'b0;
      acc     = '0;
      if (rv_ff && pop) begin
         rv_in = 1'b0;
      end
      if (mul_start || sqrt_start || div_start) begin
         busy_in = 1'b1;
      end
      if (mul_done || sqrt_done || div_done) begin
         busy_in = 1'b0;
      end
      case (st_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_data;
               w_in    = '0;
               idx_in  = '0;
               st_in   = q_data.skip ? S_MISS : S_A;
            end
         end
         S_A: begin
            if (mul_done) begin
               acc    = sat_add(w_ff.a, mul_prod);
               w_in.a = acc;
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  idx_in = '0;
                  st_in  = (acc <= 0) ? S_MISS : S_H;
               end
            end
         end
         S_H: begin
            if (mul_done) begin
               w_in.h = sat_add(w_ff.h, mul_prod);
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  idx_in = '0;
                  st_in  = S_C;
               end
            end
         end
         S_C: begin
            if (mul_done) begin
               w_in.cc = sat_add(w_ff.cc, mul_prod);
               idx_in  = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  idx_in = '0;
                  st_in  = S_R;
               end
            end
         end
         S_R: begin
            if (mul_done) begin
               w_in.cc = sat_sub(w_ff.cc, mul_prod);
               st_in   = S_HH;
            end
         end
         S_HH: begin
            if (mul_done) begin
               w_in.tmp = mul_prod;
               st_in    = S_AC;
            end
         end
         S_AC: begin
            if (mul_done) begin
               acc      = sat_sub(w_ff.tmp, mul_prod);
               w_in.tmp = acc;
               st_in    = (acc < 0) ? S_MISS : S_SQ;
            end
         end
         S_SQ: begin
            if (sqrt_done) begin
               w_in.s = root;
               st_in  = S_D1;
            end
         end
         S_D1: begin
            if (div_done) begin
               w_in.t = quo;
               st_in  = in_win ? S_P : S_D2;
            end
         end
         S_D2: begin
            if (div_done) begin
               w_in.t = quo;
               st_in  = in_win ? S_P : S_MISS;
            end
         end
         S_P: begin
            if (mul_done) begin
               w_in.p[idx_ff] = clamp32(sat_add(64'($signed(o_sel)), mul_prod));
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  idx_in = '0;
                  st_in  = S_N;
               end
            end
         end
         S_N: begin
            if (mul_done) begin
               w_in.nn = sat_add(w_ff.nn, mul_prod);
               idx_in  = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  idx_in = '0;
                  st_in  = S_L;
               end
            end
         end
         S_L: begin
            if (sqrt_done) begin
               w_in.len = root;
               st_in    = (root == '0) ? S_OUT : S_Q;
            end
         end
         S_Q: begin
            if (div_done) begin
               if (quo > NRM_ONE) begin
                  w_in.nrm[idx_ff] = NRM_W'(NRM_ONE);
               end else if (quo < -NRM_ONE) begin
                  w_in.nrm[idx_ff] = NRM_W'(-NRM_ONE);
               end else begin
                  w_in.nrm[idx_ff] = quo[NRM_W-1:0];
               end
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd2) begin
                  idx_in = '0;
                  st_in  = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rv_ff || pop) begin
               rsp_in.hit   = 1'b1;
               rsp_in.t     = w_ff.t[31:0];
               rsp_in.p     = w_ff.p;
               rsp_in.nrm   = w_ff.nrm;
               rsp_in.color = cfg.color;
               rv_in        = 1'b1;
               st_in        = S_IDLE;
            end
         end
         S_MISS: begin
            if (!rv_ff || pop) begin
               rsp_in = '0;
               rv_in  = 1'b1;
               st_in  = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         idx_ff  <= '0;
         busy_ff <= 1'b0;
         rv_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
         rv_ff   <= rv_in;
      end
      item_ff <= item_in;
      w_ff    <= w_in;
      rsp_ff  <= rsp_in;
   end

endmodule

/* rtl/core/ray_sphere_intersection_top.sv */
// Ray/sphere test in Q16.16 fixed point. A ray is taken on push when full is
// low; the front registers it, forms origin minus center, flags an empty t window
// and hands it to a four-word queue, so new rays keep being taken while the back
// end works. The back end runs one ray at a time through a shared 64-bit multiply
// sequence, a 40-step square root and a 32-step divider, so the back end sets the
// rate: a ray rejected by its window, by a zero direction or on the discriminant
// ends early, and a hit that takes the far root runs a second divide. One result
// word per ray waits on the rsp_ ports while empty is low and leaves on pop. The
// sphere registers are written over the APB port at byte addresses 0, 4, 8, 12 and
// 16; the user must write them only while no ray is in flight, which the block
// itself does not enforce.
module ray_sphere_intersection_top import rsi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_origin_x,
   input  logic [31:0] req_origin_y,
   input  logic [31:0] req_origin_z,
   input  logic [31:0] req_dir_x,
   input  logic [31:0] req_dir_y,
   input  logic [31:0] req_dir_z,
   input  logic [31:0] req_t_low,
   input  logic [31:0] req_t_high,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_hit,
   output logic [31:0] rsp_hit_t,
   output logic [31:0] rsp_point_x,
   output logic [31:0] rsp_point_y,
   output logic [31:0] rsp_point_z,
   output logic [17:0] rsp_normal_x,
   output logic [17:0] rsp_normal_y,
   output logic [17:0] rsp_normal_z,
   output logic [23:0] rsp_hit_color,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   rsi_cfg_type cfg_ff, cfg_in;
   logic        wr_en;
   logic        q_full, q_push, q_empty, q_pop;
   rsi_ray_type q_wdata, q_rdata;
   rsi_rsp_type rsp;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[4:2])
            REG_CX:    cfg_in.cx     = pwdata;
            REG_CY:    cfg_in.cy     = pwdata;
            REG_CZ:    cfg_in.cz     = pwdata;
            REG_RAD:   cfg_in.radius = pwdata[30:0];
            REG_COLOR: cfg_in.color  = pwdata[23:0];
            default:   cfg_in        = cfg_ff;
         endcase
      end
      case (paddr[4:2])
         REG_CX:    prdata = cfg_ff.cx;
         REG_CY:    prdata = cfg_ff.cy;
         REG_CZ:    prdata = cfg_ff.cz;
         REG_RAD:   prdata = {1'b0, cfg_ff.radius};
         REG_COLOR: prdata = {8'b0, cfg_ff.color};
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cx     <= '0;
         cfg_ff.cy     <= '0;
         cfg_ff.cz     <= '0;
         cfg_ff.radius <= 31'd65536;
         cfg_ff.color  <= 24'hFF_FFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rsi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .origin_x (req_origin_x),
      .origin_y (req_origin_y),
      .origin_z (req_origin_z),
      .dir_x    (req_dir_x),
      .dir_y    (req_dir_y),
      .dir_z    (req_dir_z),
      .t_low    (req_t_low),
      .t_high   (req_t_high),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   rsi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .data_out (q_rdata)
   );

   rsi_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_data  (q_rdata),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .rsp     (rsp)
   );

   assign rsp_hit       = rsp.hit;
   assign rsp_hit_t     = rsp.t;
   assign rsp_point_x   = rsp.p[0];
   assign rsp_point_y   = rsp.p[1];
   assign rsp_point_z   = rsp.p[2];
   assign rsp_normal_x  = rsp.nrm[0];
   assign rsp_normal_y  = rsp.nrm[1];
   assign rsp_normal_z  = rsp.nrm[2];
   assign rsp_hit_color = rsp.color;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_hit) |-> (rsp_hit_t == 32'd0 && rsp_hit_color == 24'd0
                                && rsp_normal_x == 18'd0 && rsp_point_x == 32'd0))
      else $error("miss word carries nonzero payload");
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> ($signed(rsp_normal_x) <= 18'sd65536 && $signed(rsp_normal_x) >= -18'sd65536
                  && $signed(rsp_normal_y) <= 18'sd65536
                  && $signed(rsp_normal_y) >= -18'sd65536
                  && $signed(rsp_normal_z) <= 18'sd65536
                  && $signed(rsp_normal_z) >= -18'sd65536))
      else $error("normal component out of range");
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_hit) |-> (rsp_hit_color == cfg_ff.color))
      else $error("hit color differs from sphere color");
`endif

endmodule
